@@ rtl/core/sfr_pkg.sv @@
package sfr_pkg;

   // default viewport, whole pixels
   localparam int VIEW_WIDTH_DEF  = 640;
   localparam int VIEW_HEIGHT_DEF = 480;

   // zoom law, Q8.24
   localparam logic [19:0] ZOOM_STEP  = 20'd168;
   localparam logic [23:0] ZOOM_BAND  = 24'd167772;
   localparam logic [23:0] ZOOM_LIMIT = 24'd1677722;
   localparam logic [31:0] ZOOM_ONE   = 32'h0100_0000;

   // register reset values
   localparam logic [19:0] ACCEL_STEP_RST    = 20'd655;
   localparam logic [23:0] MAX_VELOCITY_RST  = 24'd131072;
   localparam logic [15:0] FRICTION_GAIN_RST = 16'd52429;
   localparam logic [23:0] DEAD_BAND_RST     = 24'd327680;
   localparam logic [15:0] MAP_WIDTH_RST     = 16'd4096;
   localparam logic [15:0] MAP_HEIGHT_RST    = 16'd4096;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ACCEL_STEP    = 3'd0,
      CSR_MAX_VELOCITY  = 3'd1,
      CSR_FRICTION_GAIN = 3'd2,
      CSR_DEAD_BAND     = 3'd3,
      CSR_MAP_WIDTH     = 3'd4,
      CSR_MAP_HEIGHT    = 3'd5
   } csr_addr_type;

   // control law of one axis
   typedef struct packed {
      logic [23:0] band;
      logic [19:0] step;
      logic [23:0] limit;
      logic [15:0] gain;
   } sfr_law_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -33'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/scroll_follow_regulator_top.sv @@
// A request is held in the input register, its result in the result register; the
// whole tick resolves between them. One request per cycle unless rsp_stall holds a result.
// A finished result may wait under rsp_stall while the next request is taken in.
// Reset (synchronous, active high): positions and velocities zero, zoom 1.0,
// registers to their defaults, both pipeline stages empty.
module scroll_follow_regulator_top #(
   parameter int VIEW_WIDTH  = sfr_pkg::VIEW_WIDTH_DEF,
   parameter int VIEW_HEIGHT = sfr_pkg::VIEW_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_target_x,
   input  logic signed [31:0]                req_target_y,
   input  logic [30:0]                       req_target_zoom,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_offset_x,
   output logic signed [31:0]                rsp_offset_y,
   output logic signed [31:0]                rsp_zoom_level,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sfr_pkg::*;

   logic [19:0] accel_step_ff;
   logic [23:0] max_velocity_ff;
   logic [15:0] friction_gain_ff;
   logic [23:0] dead_band_ff;
   logic [15:0] map_width_ff;
   logic [15:0] map_height_ff;

   logic              in_vld_ff;
   logic signed [31:0] tgt_x_ff, tgt_y_ff;
   logic [30:0]       tgt_z_ff;

   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff, zoom_ff, zoom_vel_ff;
   logic signed [31:0] pos_x_in, pos_y_in, vel_x_in, vel_y_in, zoom_in, zoom_vel_in;
   logic signed [32:0] sum_x, sum_y, sum_z;

   logic              out_vld_ff;
   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff;

   logic        out_free, advance;
   sfr_law_type law_xy, law_z;

   assign csr_ready = 1'b1;
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_step_ff    <= ACCEL_STEP_RST;
         max_velocity_ff  <= MAX_VELOCITY_RST;
         friction_gain_ff <= FRICTION_GAIN_RST;
         dead_band_ff     <= DEAD_BAND_RST;
         map_width_ff     <= MAP_WIDTH_RST;
         map_height_ff    <= MAP_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACCEL_STEP:    accel_step_ff    <= csr_data[19:0];
            CSR_MAX_VELOCITY:  max_velocity_ff  <= csr_data[23:0];
            CSR_FRICTION_GAIN: friction_gain_ff <= csr_data[15:0];
            CSR_DEAD_BAND:     dead_band_ff     <= csr_data[23:0];
            CSR_MAP_WIDTH:     map_width_ff     <= csr_data[15:0];
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         tgt_x_ff <= req_target_x;
         tgt_y_ff <= req_target_y;
         tgt_z_ff <= req_target_zoom;
      end
   end

   assign law_xy = '{band: dead_band_ff, step: accel_step_ff,
                     limit: max_velocity_ff, gain: friction_gain_ff};
   assign law_z  = '{band: ZOOM_BAND, step: ZOOM_STEP,
                     limit: ZOOM_LIMIT, gain: friction_gain_ff};

   sfr_axis u_axis_x (
      .pos(pos_x_ff), .target(tgt_x_ff), .vel(vel_x_ff), .law(law_xy),
      .vel_next(vel_x_in), .pos_sum(sum_x)
   );

   sfr_axis u_axis_y (
      .pos(pos_y_ff), .target(tgt_y_ff), .vel(vel_y_ff), .law(law_xy),
      .vel_next(vel_y_in), .pos_sum(sum_y)
   );

   sfr_axis u_axis_z (
      .pos(zoom_ff), .target($signed({1'b0, tgt_z_ff})), .vel(zoom_vel_ff), .law(law_z),
      .vel_next(zoom_vel_in), .pos_sum(sum_z)
   );

   sfr_clamp #(.VIEW(VIEW_WIDTH)) u_clamp_x (
      .pos_sum(sum_x), .map_size(map_width_ff), .pos_out(pos_x_in)
   );

   sfr_clamp #(.VIEW(VIEW_HEIGHT)) u_clamp_y (
      .pos_sum(sum_y), .map_size(map_height_ff), .pos_out(pos_y_in)
   );

   assign zoom_in = sat32(sum_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         vel_x_ff    <= '0;
         vel_y_ff    <= '0;
         zoom_ff     <= ZOOM_ONE;
         zoom_vel_ff <= '0;
      end else if (advance) begin
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         vel_x_ff    <= vel_x_in;
         vel_y_ff    <= vel_y_in;
         zoom_ff     <= zoom_in;
         zoom_vel_ff <= zoom_vel_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff <= pos_x_in;
         out_y_ff <= pos_y_in;
         out_z_ff <= zoom_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_offset_x   = out_x_ff;
   assign rsp_offset_y   = out_y_ff;
   assign rsp_zoom_level = out_z_ff;

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request advanced but no result registered");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_vld_ff) |=> !rsp_valid)
      else $error("result repeated after being taken");

   a_vel_x_limit: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((34'(vel_x_ff) <= $signed({10'b0, $past(max_velocity_ff)})) &&
                   (34'(vel_x_ff) >= -$signed({10'b0, $past(max_velocity_ff)}))))
      else $error("x velocity beyond its limit");

   a_zoom_vel_limit: assert property (@(posedge clock) disable iff (reset)
      (34'(zoom_vel_ff) <= $signed({10'b0, ZOOM_LIMIT})) &&
      (34'(zoom_vel_ff) >= -$signed({10'b0, ZOOM_LIMIT})))
      else $error("zoom velocity beyond its limit");

endmodule

@@ rtl/core/sfr_axis.sv @@
module sfr_axis (
   input  logic signed [31:0] pos,
   input  logic signed [31:0] target,
   input  logic signed [31:0] vel,
   input  sfr_pkg::sfr_law_type law,
   output logic signed [31:0] vel_next,
   output logic signed [32:0] pos_sum
);
   import sfr_pkg::*;

   logic signed [33:0] pos_w, lo_w, hi_w, lim_w, stepped, fric_w, pre_w, post_w;
   logic [31:0] mag;
   logic [47:0] prod;
   logic [31:0] fric_mag;

   assign pos_w = 34'(pos);
   assign lo_w  = 34'(target) - $signed({10'b0, law.band});
   assign hi_w  = 34'(target) + $signed({10'b0, law.band});
   assign lim_w = $signed({10'b0, law.limit});

   // friction on magnitude, truncation toward zero
   assign mag      = vel[31] ? (~vel + 32'd1) : vel;
   assign prod     = 48'(mag) * 48'(law.gain);
   assign fric_mag = prod[47:16];
   assign fric_w   = vel[31] ? -$signed({2'b0, fric_mag}) : $signed({2'b0, fric_mag});

   always_comb begin
      stepped = 34'(vel);
      if (pos_w < lo_w) begin
         stepped = 34'(vel) + $signed({14'b0, law.step});
      end else if (pos_w > hi_w) begin
         stepped = 34'(vel) - $signed({14'b0, law.step});
      end
      pre_w = ((pos_w < lo_w) || (pos_w > hi_w)) ? stepped : fric_w;
      if (pre_w > lim_w) begin
         post_w = lim_w;
      end else if (pre_w < -lim_w) begin
         post_w = -lim_w;
      end else begin
         post_w = pre_w;
      end
   end

   assign vel_next = post_w[31:0];
   assign pos_sum  = 33'(pos) + 33'(vel_next);

endmodule

@@ rtl/core/sfr_clamp.sv @@
module sfr_clamp #(
   parameter int VIEW = sfr_pkg::VIEW_WIDTH_DEF
) (
   input  logic signed [32:0] pos_sum,
   input  logic [15:0]        map_size,
   output logic signed [31:0] pos_out
);
   import sfr_pkg::*;

   logic signed [16:0] diff;
   logic signed [32:0] bound_raw;
   logic signed [32:0] bound;

   assign diff      = $signed({1'b0, map_size}) - $signed(17'(VIEW));
   assign bound_raw = {diff, 16'b0};
   assign bound     = 33'(sat32(bound_raw));

   always_comb begin
      if (pos_sum[32]) begin
         pos_out = '0;
      end else if (pos_sum > bound) begin
         pos_out = bound[31:0];
      end else begin
         pos_out = pos_sum[31:0];
      end
   end

endmodule
